// File: design/csvq_pkg.sv
// Shared constants, codes and helpers for the CSV cell quoting encoder.
`default_nettype none
package csvq_pkg;

	localparam int CELL_BYTES  = 16;
	localparam int MAX_COLUMNS = 16;
	localparam int MAX_ROWS    = 256;

	localparam int ADDR_W     = $clog2(CELL_BYTES);
	localparam int COL_W      = $clog2(MAX_COLUMNS + 1);
	localparam int ROW_W      = $clog2(MAX_ROWS + 1);
	localparam int POS_W      = 16;
	localparam int CFG_COL_W  = 5;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CAPACITY  = 2'd1;
	localparam logic [1:0] ST_ROWS      = 2'd2;
	localparam logic [1:0] ST_CELL_LONG = 2'd3;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [POS_W-1:0] CAPACITY_RESET = 16'hFFFF;
	localparam logic [CFG_COL_W-1:0] COLUMNS_RESET = 5'd16;

	// zero acts as one column, anything above the limit as the limit
	function automatic logic [COL_W-1:0] clamp_columns(input logic [CFG_COL_W-1:0] v);
		logic [COL_W-1:0] r;
		if (v == '0)
			r = COL_W'(1);
		else if (int'(v) > MAX_COLUMNS)
			r = COL_W'(MAX_COLUMNS);
		else
			r = COL_W'(v);
		return r;
	endfunction

	function automatic logic is_special(input logic [7:0] b);
		return (b == CH_COMMA) || (b == CH_QUOTE) || (b == CH_LF) || (b == CH_CR);
	endfunction

endpackage
`default_nettype wire

// File: design/csv_cell_quoting_encoder_core.sv
// CSV cell quoting encoder: cell buffer memory, output sequencer and result register.
//
// Input channel (in_valid/in_ready) takes one item per handshake: an optional cell
// byte, a cell end mark and a table end mark. Bytes go into a 16-entry cell memory,
// one per cycle while the sequencer is idle; a byte-only item causes no result.
// On cell end the sequencer replays the buffered cell from the memory, doubling
// each quote, with its leading comma, quotes and row-ending LF where they apply.
// On table end a partial row is padded, then a status item carries the error code and
// output length. Results leave on out_valid/out_ready; last marks the final result
// of an input item.
// in_ready is high only while the sequencer is idle; a result register and a
// one-deep pending slot decouple the output, so a stalled receiver simply holds
// the sequencer. After reset: no error, empty cell, column and row zero, 16
// columns and a capacity of 65535; the cell memory content is not cleared.
`default_nettype none
module csv_cell_quoting_encoder_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 has_byte,
	input  wire logic [7:0]                           cell_byte,
	input  wire logic                                 cell_end,
	input  wire logic                                 table_end,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [7:0]                                out_byte,
	output logic                                      byte_valid,
	output logic [1:0]                                status,
	output logic [csvq_pkg::POS_W-1:0]                csv_len,
	output logic                                      last,
	input  wire logic                                 cfg_we,
	input  wire logic [csvq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [csvq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_ENC, S_COMMA, S_OPENQ, S_BODY, S_DQ, S_CLOSEQ, S_COLEND,
		S_LF, S_TEND, S_PAD, S_PADLF, S_STATUS, S_FLUSH
	} state_t;

	state_t state_q;

	logic [csvq_pkg::COL_W-1:0]  col_cnt_q;
	logic [csvq_pkg::POS_W-1:0]  cap_q;

	logic [csvq_pkg::ADDR_W-1:0] fill_q;
	logic                        quote_q;
	logic [csvq_pkg::COL_W-1:0]  col_q;
	logic [csvq_pkg::ROW_W-1:0]  row_q;
	logic [csvq_pkg::POS_W-1:0]  pos_q;
	logic [1:0]                  err_q;
	logic [csvq_pkg::ADDR_W-1:0] idx_q;

	// cell memory, one write port, one registered read port
	logic [7:0] cell_mem [csvq_pkg::CELL_BYTES];
	logic [7:0] rd_data_q;

	// pending result, held back one step so that its last flag is known
	logic                        pend_valid_q;
	logic [7:0]                  pend_byte_q;
	logic                        pend_bv_q;
	logic [1:0]                  pend_status_q;
	logic [csvq_pkg::POS_W-1:0]  pend_len_q;

	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        out_bv_q;
	logic [1:0]                  out_status_q;
	logic [csvq_pkg::POS_W-1:0]  out_len_q;
	logic                        out_last_q;

	logic                        accept;
	logic                        store_we;
	logic                        can_load;
	logic                        adv;
	logic                        fit1;
	logic                        fit2;
	logic [csvq_pkg::POS_W:0]    pos_ext;
	logic [csvq_pkg::POS_W:0]    cap_ext;
	logic [csvq_pkg::POS_W-1:0]  pos_inc;
	logic [csvq_pkg::COL_W-1:0]  col_inc;
	logic [csvq_pkg::ADDR_W-1:0] idx_inc;
	logic [csvq_pkg::ADDR_W-1:0] idx_d;
	logic                        idx_step;
	logic                        body_last;
	logic                        rd_is_quote;
	state_t                      after_prefix;
	state_t                      after_body;

	logic                        emit;
	logic [7:0]                  e_byte;
	logic                        e_valid;
	logic                        flush;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign store_we = accept && has_byte && (cell_byte != csvq_pkg::CH_NUL)
		&& (fill_q < csvq_pkg::ADDR_W'(csvq_pkg::CELL_BYTES - 1));

	assign can_load = !out_valid_q || out_ready;
	assign adv      = !pend_valid_q || can_load;

	assign pos_ext = {1'b0, pos_q};
	assign cap_ext = {1'b0, cap_q};
	assign fit1    = (pos_ext + 17'd1) < cap_ext;
	assign fit2    = (pos_ext + 17'd2) < cap_ext;
	assign pos_inc = pos_q + 1'b1;
	assign col_inc = col_q + 1'b1;
	assign idx_inc = idx_q + 1'b1;

	assign rd_is_quote = (rd_data_q == csvq_pkg::CH_QUOTE);
	assign body_last   = (idx_inc == fill_q);

	assign after_prefix = quote_q ? S_OPENQ : ((fill_q != '0) ? S_BODY : S_COLEND);
	assign after_body   = quote_q ? S_CLOSEQ : S_COLEND;

	// a body byte is consumed when it goes out; a quote is consumed by its second copy
	assign idx_step = adv && (((state_q == S_BODY) && !rd_is_quote && fit1)
		|| (state_q == S_DQ));

	always_comb begin
		if (state_q == S_IDLE)
			idx_d = '0;
		else if (idx_step)
			idx_d = idx_inc;
		else
			idx_d = idx_q;
	end

	always_comb begin
		emit    = 1'b0;
		e_byte  = csvq_pkg::CH_NUL;
		e_valid = 1'b1;
		unique case (state_q)
			S_COMMA: begin
				emit   = adv && fit1;
				e_byte = csvq_pkg::CH_COMMA;
			end
			S_OPENQ, S_CLOSEQ: begin
				emit   = adv && fit1;
				e_byte = csvq_pkg::CH_QUOTE;
			end
			S_BODY: begin
				emit   = adv && (rd_is_quote ? fit2 : fit1);
				e_byte = rd_data_q;
			end
			S_DQ: begin
				emit   = adv;
				e_byte = csvq_pkg::CH_QUOTE;
			end
			S_LF, S_PADLF: begin
				emit   = adv && fit1;
				e_byte = csvq_pkg::CH_LF;
			end
			S_PAD: begin
				emit   = adv && (col_q < col_cnt_q) && fit1;
				e_byte = csvq_pkg::CH_COMMA;
			end
			S_STATUS: begin
				emit    = adv;
				e_valid = 1'b0;
			end
			S_IDLE, S_ENC, S_COLEND, S_TEND, S_FLUSH: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign flush = (state_q == S_FLUSH) && pend_valid_q && can_load;

	always_ff @(posedge clk) begin
		if (store_we)
			cell_mem[fill_q] <= cell_byte;
		rd_data_q <= cell_mem[idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			col_cnt_q     <= csvq_pkg::clamp_columns(csvq_pkg::COLUMNS_RESET);
			cap_q         <= csvq_pkg::CAPACITY_RESET;
			fill_q        <= '0;
			quote_q       <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			pos_q         <= '0;
			err_q         <= csvq_pkg::ST_OK;
			idx_q         <= '0;
			pend_valid_q  <= 1'b0;
			pend_byte_q   <= '0;
			pend_bv_q     <= 1'b0;
			pend_status_q <= csvq_pkg::ST_OK;
			pend_len_q    <= '0;
			out_valid_q   <= 1'b0;
			out_byte_q    <= '0;
			out_bv_q      <= 1'b0;
			out_status_q  <= csvq_pkg::ST_OK;
			out_len_q     <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					csvq_pkg::REG_COLUMN_COUNT:
						col_cnt_q <= csvq_pkg::clamp_columns(
							cfg_data[csvq_pkg::CFG_COL_W-1:0]);
					csvq_pkg::REG_OUTPUT_CAPACITY:
						cap_q <= cfg_data[csvq_pkg::POS_W-1:0];
					default: begin
					end
				endcase
			end

			idx_q <= idx_d;

			// result register and pending slot
			if (emit) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					out_byte_q   <= pend_byte_q;
					out_bv_q     <= pend_bv_q;
					out_status_q <= pend_status_q;
					out_len_q    <= pend_len_q;
					out_last_q   <= 1'b0;
				end else if (can_load) begin
					out_valid_q <= 1'b0;
				end
				pend_valid_q  <= 1'b1;
				pend_byte_q   <= e_byte;
				pend_bv_q     <= e_valid;
				pend_status_q <= err_q;
				pend_len_q    <= e_valid ? pos_inc : pos_q;
			end else if (flush) begin
				out_valid_q  <= 1'b1;
				out_byte_q   <= pend_byte_q;
				out_bv_q     <= pend_bv_q;
				out_status_q <= pend_status_q;
				out_len_q    <= pend_len_q;
				out_last_q   <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (can_load) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == S_IDLE) begin
				if (accept) begin
					if (has_byte && (cell_byte != csvq_pkg::CH_NUL)) begin
						if (store_we) begin
							fill_q <= fill_q + 1'b1;
							if (csvq_pkg::is_special(cell_byte))
								quote_q <= 1'b1;
						end else if (err_q == csvq_pkg::ST_OK) begin
							err_q <= csvq_pkg::ST_CELL_LONG;
						end
					end
					if (cell_end)
						state_q <= S_ENC;
					else if (table_end)
						state_q <= S_TEND;
				end
			end else if (adv) begin
				unique case (state_q)
					S_ENC: begin
						if (err_q != csvq_pkg::ST_OK) begin
							state_q <= S_FLUSH;
						end else if ((col_q == '0)
							&& (row_q >= csvq_pkg::ROW_W'(csvq_pkg::MAX_ROWS))) begin
							err_q   <= csvq_pkg::ST_ROWS;
							state_q <= S_FLUSH;
						end else if (col_q != '0) begin
							state_q <= S_COMMA;
						end else begin
							state_q <= after_prefix;
						end
					end
					S_COMMA: begin
						if (fit1) begin
							pos_q   <= pos_inc;
							state_q <= after_prefix;
						end else begin
							err_q   <= csvq_pkg::ST_CAPACITY;
							state_q <= S_FLUSH;
						end
					end
					S_OPENQ: begin
						if (fit1) begin
							pos_q   <= pos_inc;
							state_q <= (fill_q != '0) ? S_BODY : S_CLOSEQ;
						end else begin
							err_q   <= csvq_pkg::ST_CAPACITY;
							state_q <= S_FLUSH;
						end
					end
					S_BODY: begin
						if (rd_is_quote ? fit2 : fit1) begin
							pos_q <= pos_inc;
							if (rd_is_quote)
								state_q <= S_DQ;
							else if (body_last)
								state_q <= after_body;
						end else begin
							err_q   <= csvq_pkg::ST_CAPACITY;
							state_q <= S_FLUSH;
						end
					end
					S_DQ: begin
						// room for both copies was checked with the first one
						pos_q   <= pos_inc;
						state_q <= body_last ? after_body : S_BODY;
					end
					S_CLOSEQ: begin
						if (fit1) begin
							pos_q   <= pos_inc;
							state_q <= S_COLEND;
						end else begin
							err_q   <= csvq_pkg::ST_CAPACITY;
							state_q <= S_FLUSH;
						end
					end
					S_COLEND: begin
						col_q   <= col_inc;
						state_q <= (col_inc >= col_cnt_q) ? S_LF : S_FLUSH;
					end
					S_LF: begin
						if (fit1) begin
							pos_q <= pos_inc;
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							err_q <= csvq_pkg::ST_CAPACITY;
						end
						state_q <= S_FLUSH;
					end
					S_TEND: begin
						if ((err_q == csvq_pkg::ST_OK) && (col_q != '0))
							state_q <= S_PAD;
						else
							state_q <= S_STATUS;
					end
					S_PAD: begin
						if (col_q < col_cnt_q) begin
							if (fit1) begin
								pos_q <= pos_inc;
								col_q <= col_inc;
							end else begin
								err_q   <= csvq_pkg::ST_CAPACITY;
								state_q <= S_STATUS;
							end
						end else begin
							state_q <= S_PADLF;
						end
					end
					S_PADLF: begin
						if (fit1)
							pos_q <= pos_inc;
						else
							err_q <= csvq_pkg::ST_CAPACITY;
						state_q <= S_STATUS;
					end
					S_STATUS: begin
						// status item is latched this cycle, then the table restarts
						col_q   <= '0;
						row_q   <= '0;
						pos_q   <= '0;
						err_q   <= csvq_pkg::ST_OK;
						state_q <= S_FLUSH;
					end
					S_FLUSH: begin
						fill_q  <= '0;
						quote_q <= 1'b0;
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						state_q <= S_IDLE;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = out_bv_q;
	assign status     = out_status_q;
	assign csv_len    = out_len_q;
	assign last       = out_last_q;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the CSV cell quoting encoder core.
module tb_top;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic       has_chr;
		logic [7:0] chr;
		logic       end_cell;
		logic       end_table;
	} cell_item_t;

	typedef struct packed {
		logic [7:0]                 chr;
		logic                       chr_ok;
		logic [1:0]                 stat;
		logic [csvq_pkg::POS_W-1:0] len;
		logic                       fin;
	} csv_result_t;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	logic has_byte = 1'b0;
	logic [7:0] cell_byte = 8'h00;
	logic cell_end = 1'b0;
	logic table_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [7:0] out_byte;
	logic byte_valid;
	logic [1:0] status;
	logic [csvq_pkg::POS_W-1:0] csv_len;
	logic last;
	logic cfg_we;
	logic [csvq_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [csvq_pkg::CFG_DATA_W-1:0] cfg_data;

	csv_cell_quoting_encoder_core DUT (.*);

	// stimulus and bookkeeping
	cell_item_t cell_items_q[$];
	cell_item_t next_item;
	csv_result_t csv_expected_q[$];
	csv_result_t want_res;
	csv_result_t seen_res;
	int items_queued = 0;
	int items_taken = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit calm = 1'b0;

	// encoder model state
	logic [7:0] cell_buf [0:csvq_pkg::CELL_BYTES-1];
	int cell_len = 0;
	bit cell_quoted = 1'b0;
	int col_pos = 0;
	int row_cnt = 0;
	int out_pos = 0;
	logic [1:0] err_code = csvq_pkg::ST_OK;
	int cols_eff = csvq_pkg::MAX_COLUMNS;
	int capacity = 65535;
	csv_result_t held_res;
	bit held_ok = 1'b0;

	// results are held back one step so the final one of an item can carry its last flag
	function automatic void stage(input logic [7:0] c, input logic ok);
		if (held_ok)
			csv_expected_q.push_back(held_res);
		held_res = '{c, ok, err_code, csvq_pkg::POS_W'(out_pos), 1'b0};
		held_ok = 1'b1;
	endfunction

	function automatic bit fits(input int n);
		if (err_code != csvq_pkg::ST_OK)
			return 1'b0;
		if (out_pos + n >= capacity) begin
			err_code = csvq_pkg::ST_CAPACITY;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit put_char(input logic [7:0] c);
		if (!fits(1))
			return 1'b0;
		out_pos++;
		stage(c, 1'b1);
		return 1'b1;
	endfunction

	task automatic encode_cell_chars();
		logic [7:0] c;
		if (err_code != csvq_pkg::ST_OK)
			return;
		if (col_pos == 0 && row_cnt >= csvq_pkg::MAX_ROWS) begin
			err_code = csvq_pkg::ST_ROWS;
			return;
		end
		if (col_pos > 0 && !put_char(csvq_pkg::CH_COMMA))
			return;
		if (cell_quoted && !put_char(csvq_pkg::CH_QUOTE))
			return;
		for (int i = 0; i < cell_len; i++) begin
			c = cell_buf[i];
			if (c == csvq_pkg::CH_QUOTE) begin
				if (!fits(2))
					return;
				out_pos++;
				stage(csvq_pkg::CH_QUOTE, 1'b1);
				out_pos++;
				stage(csvq_pkg::CH_QUOTE, 1'b1);
			end else if (!put_char(c)) begin
				return;
			end
		end
		if (cell_quoted && !put_char(csvq_pkg::CH_QUOTE))
			return;
		col_pos++;
		if (col_pos >= cols_eff) begin
			if (!put_char(csvq_pkg::CH_LF))
				return;
			col_pos = 0;
			row_cnt++;
		end
	endtask

	task automatic close_table();
		bit ok;
		if (err_code == csvq_pkg::ST_OK && col_pos > 0) begin
			ok = 1'b1;
			while (ok && col_pos < cols_eff) begin
				ok = put_char(csvq_pkg::CH_COMMA);
				if (ok)
					col_pos++;
			end
			if (ok && put_char(csvq_pkg::CH_LF)) begin
				col_pos = 0;
				row_cnt++;
			end
		end
		stage(csvq_pkg::CH_NUL, 1'b0);
		cell_len = 0;
		cell_quoted = 1'b0;
		col_pos = 0;
		row_cnt = 0;
		out_pos = 0;
		err_code = csvq_pkg::ST_OK;
	endtask

	task automatic predict_csv(input cell_item_t it);
		if (it.has_chr && it.chr != csvq_pkg::CH_NUL) begin
			if (cell_len >= csvq_pkg::CELL_BYTES - 1) begin
				if (err_code == csvq_pkg::ST_OK)
					err_code = csvq_pkg::ST_CELL_LONG;
			end else begin
				cell_buf[cell_len] = it.chr;
				cell_len++;
				if (csvq_pkg::is_special(it.chr))
					cell_quoted = 1'b1;
			end
		end
		if (it.end_cell) begin
			encode_cell_chars();
			cell_len = 0;
			cell_quoted = 1'b0;
		end else if (it.end_table) begin
			close_table();
		end
		if (held_ok) begin
			held_res.fin = 1'b1;
			csv_expected_q.push_back(held_res);
			held_ok = 1'b0;
		end
	endtask

	// stimulus helpers
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return csvq_pkg::CH_COMMA;
		else if (r < 16)
			return csvq_pkg::CH_QUOTE;
		else if (r < 20)
			return csvq_pkg::CH_CR;
		else if (r < 24)
			return csvq_pkg::CH_LF;
		else if (r < 27)
			return csvq_pkg::CH_NUL;
		return 8'($urandom_range(255));
	endfunction

	function automatic int cell_size();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 6);
		else if (r < 95)
			return $urandom_range(7, csvq_pkg::CELL_BYTES - 2);
		return $urandom_range(csvq_pkg::CELL_BYTES - 1, csvq_pkg::CELL_BYTES + 2);
	endfunction

	task automatic push_item(input logic h, input logic [7:0] c, input logic ce,
			input logic te);
		cell_items_q.push_back('{h, c, ce, te});
		items_queued++;
	endtask

	task automatic add_cell(input int n);
		logic h;
		repeat (n) push_item(1'b1, pick_char(), 1'b0, 1'b0);
		h = 1'($urandom_range(1));
		push_item(h, h ? pick_char() : 8'($urandom_range(255)), 1'b1,
			$urandom_range(19) == 0);
	endtask

	task automatic add_table(input int ncells);
		repeat (ncells) add_cell(cell_size());
		push_item(1'($urandom_range(1)), pick_char(), 1'b0, 1'b1);
	endtask

	task automatic set_config(input int cols, input int cap);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= csvq_pkg::REG_COLUMN_COUNT;
		cfg_data <= csvq_pkg::CFG_DATA_W'(cols);
		cols_eff = (cols == 0) ? 1 :
			((cols > csvq_pkg::MAX_COLUMNS) ? csvq_pkg::MAX_COLUMNS : cols);
		@(posedge clk);
		cfg_index <= csvq_pkg::REG_OUTPUT_CAPACITY;
		cfg_data <= csvq_pkg::CFG_DATA_W'(cap);
		capacity = cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || csv_expected_q.size() != 0)
			@(posedge clk);
		// items with no result may still keep the sequencer busy
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int cols, input int cap, input int n);
		int start;
		set_config(cols, cap);
		start = items_queued;
		while (items_queued - start < n) begin
			if ($urandom_range(99) < 85)
				add_table($urandom_range(0, 5));
			else
				repeat ($urandom_range(1, 4))
					push_item(1'($urandom_range(1)), 8'($urandom_range(255)),
						$urandom_range(3) == 0, $urandom_range(5) == 0);
		end
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// input side
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (cell_items_q.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
				next_item = cell_items_q.pop_front();
				in_valid <= 1'b1;
				has_byte <= next_item.has_chr;
				cell_byte <= next_item.chr;
				cell_end <= next_item.end_cell;
				table_end <= next_item.end_table;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b1;
		else
			out_ready <= calm || ($urandom_range(99) >= 26);
	end

	// prediction on each accepted item, then check of each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				items_taken++;
				predict_csv('{has_byte, cell_byte, cell_end, table_end});
			end
			if (out_valid && out_ready) begin
				seen_res = '{out_byte, byte_valid, status, csv_len, last};
				if (csv_expected_q.size() == 0) begin
					mismatch_count++;
					$display({"%0t: expected no result",
						" got chr=%h ok=%b st=%0d len=%0d last=%b"},
						$time, seen_res.chr, seen_res.chr_ok, seen_res.stat,
						seen_res.len, seen_res.fin);
				end else begin
					want_res = csv_expected_q.pop_front();
					if (seen_res !== want_res) begin
						mismatch_count++;
						$display({"%0t: mismatch expected chr=%h ok=%b st=%0d len=%0d last=%b",
							" got chr=%h ok=%b st=%0d len=%0d last=%b"}, $time,
							want_res.chr, want_res.chr_ok, want_res.stat, want_res.len,
							want_res.fin, seen_res.chr, seen_res.chr_ok, seen_res.stat,
							seen_res.len, seen_res.fin);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("csv_cell_quoting_encoder_core verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = csvq_pkg::REG_COLUMN_COUNT;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_config(3, 65535);
		push_item(1'b1, 8'h01, 1'b1, 1'b0);                // opens the row, no comma
		push_item(1'b1, csvq_pkg::CH_COMMA, 1'b0, 1'b0);
		push_item(1'b1, csvq_pkg::CH_QUOTE, 1'b1, 1'b0);   // quoted, inner quote doubled
		push_item(1'b0, 8'h00, 1'b1, 1'b0);                // empty cell closes the row
		push_item(1'b0, 8'hFF, 1'b1, 1'b0);                // empty cell at row start: nothing
		push_item(1'b1, csvq_pkg::CH_NUL, 1'b0, 1'b0);     // zero byte dropped
		push_item(1'b1, csvq_pkg::CH_CR, 1'b0, 1'b0);
		push_item(1'b1, csvq_pkg::CH_LF, 1'b1, 1'b0);
		push_item(1'b1, 8'hFF, 1'b1, 1'b1);                // table end ignored beside cell end
		push_item(1'b1, 8'h7E, 1'b0, 1'b1);                // open cell thrown away
		push_item(1'b0, 8'h00, 1'b0, 1'b1);                // empty table
		push_item(1'b1, 8'h41, 1'b1, 1'b0);
		push_item(1'b0, 8'h00, 1'b0, 1'b1);                // partial row padded
		repeat (csvq_pkg::CELL_BYTES) push_item(1'b1, 8'h80, 1'b0, 1'b0);
		push_item(1'b0, 8'h00, 1'b1, 1'b0);
		push_item(1'b0, 8'h00, 1'b0, 1'b1);
		wait_idle();

		run_phase(0, 0, 8);
		run_phase(1, 1, 8);
		run_phase(31, 2, 8);
		run_phase(16, 65535, 10);
		run_phase(5, 40, 8);
		run_phase(2, 12, 8);
		repeat (2) run_phase($urandom_range(1, 20), $urandom_range(8, 300), 8);
		calm = 1'b1;
		run_phase(4, 65535, 16);
		calm = 1'b0;

		// one column per row, enough rows to run past the row limit
		set_config(1, 65535);
		repeat (csvq_pkg::MAX_ROWS + 2)
			push_item($urandom_range(3) == 0, pick_char(), 1'b1, 1'b0);
		push_item(1'b0, 8'h00, 1'b0, 1'b1);
		wait_idle();

		run_phase(7, 65534, 8);

		if (mismatch_count == 0 && csv_expected_q.size() == 0)
			$display("csv_cell_quoting_encoder_core verification clean");
		else
			$display("csv_cell_quoting_encoder_core verification failed");
		$finish;
	end
endmodule

// File: files.f
design/csvq_pkg.sv
design/csv_cell_quoting_encoder_core.sv
tb/sv/tb_top.sv
